/* src/cau_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants of the complex arithmetic unit: item formats,
// opcodes and the state carried through the divider / square-root stages.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;

  localparam int QUO_BITS  = DATA_WIDTH + 2;
  localparam int PROD_W    = 2 * DATA_WIDTH;
  localparam int MAG_W     = 2 * DATA_WIDTH - FRAC_BITS + 2;
  localparam int SQ_W      = 2 * DATA_WIDTH + 2;
  localparam int NUM_SHIFT = QUO_BITS - FRAC_BITS - 1;

  localparam logic [2:0] FUNC_ADD = 3'd0;
  localparam logic [2:0] FUNC_SUB = 3'd1;
  localparam logic [2:0] FUNC_MUL = 3'd2;
  localparam logic [2:0] FUNC_DIV = 3'd3;
  localparam logic [2:0] FUNC_MAG = 3'd4;

  typedef struct packed {
    logic [2:0]                   func;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    logic                         div_by_zero;
    logic                         overflow;
  } out_item_t;

  typedef struct packed {
    logic [2:0]            func;
    logic                  dz;
    logic                  neg_re;
    logic                  neg_im;
    logic [MAG_W-1:0]      mag_re;
    logic [MAG_W-1:0]      mag_im;
    logic [PROD_W-1:0]     num_re;
    logic [PROD_W-1:0]     num_im;
    logic [PROD_W-1:0]     rem_re;
    logic [PROD_W-1:0]     rem_im;
    logic [QUO_BITS-1:0]   quo_re;
    logic [QUO_BITS-1:0]   quo_im;
    logic                  big_re;
    logic                  big_im;
    logic [PROD_W-1:0]     den;
    logic [SQ_W-1:0]       sq_rem;
    logic [DATA_WIDTH-1:0] root;
  } iter_t;

endpackage
`default_nettype wire

/* src/cau_iter_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_iter_stage
// One registered step: one quotient bit for each of the two restoring
// dividers and, in the low stages, one root bit of the square root.
// ----------------------------------------------------------------------------
module cau_iter_stage #(
  parameter int STEP = 0
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire cau_pkg::iter_t d,
  output cau_pkg::iter_t      q
);

  localparam int   PW    = cau_pkg::PROD_W;
  localparam int   QB    = cau_pkg::QUO_BITS;
  localparam int   SQW   = cau_pkg::SQ_W;
  localparam int   DW    = cau_pkg::DATA_WIDTH;
  localparam int   FB    = cau_pkg::FRAC_BITS;
  localparam logic SQ_ON = (STEP < DW);

  logic                bit_re;
  logic                bit_im;
  logic [PW:0]         trial_re;
  logic [PW:0]         trial_im;
  logic [SQW-1:0]      sq_test;
  cau_pkg::iter_t      nxt;

  generate
    if (STEP >= FB + 1) begin : g_bit
      assign bit_re = d.num_re[STEP-FB-1];
      assign bit_im = d.num_im[STEP-FB-1];
    end else begin : g_zero
      assign bit_re = 1'b0;
      assign bit_im = 1'b0;
    end
  endgenerate

  assign trial_re = {d.rem_re, bit_re};
  assign trial_im = {d.rem_im, bit_im};
  assign sq_test  = (SQW'(d.root) << (STEP + 1)) + (SQW'(1) << (2 * STEP));

  always_comb begin
    nxt = d;
    if (trial_re >= {1'b0, d.den}) begin
      nxt.rem_re = PW'(trial_re - {1'b0, d.den});
      nxt.quo_re = {d.quo_re[QB-2:0], 1'b1};
    end else begin
      nxt.rem_re = trial_re[PW-1:0];
      nxt.quo_re = {d.quo_re[QB-2:0], 1'b0};
    end
    if (trial_im >= {1'b0, d.den}) begin
      nxt.rem_im = PW'(trial_im - {1'b0, d.den});
      nxt.quo_im = {d.quo_im[QB-2:0], 1'b1};
    end else begin
      nxt.rem_im = trial_im[PW-1:0];
      nxt.quo_im = {d.quo_im[QB-2:0], 1'b0};
    end
    if (SQ_ON && (d.sq_rem >= sq_test)) begin
      nxt.sq_rem = d.sq_rem - sq_test;
      nxt.root   = d.root | (DW'(1) << STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule
`default_nettype wire

/* src/complex_arithmetic_unit.sv */
// throughput: one item per cycle, no bubbles while the result side is ready
// the 18 restoring divider stages (one quotient bit each) set the depth
// reset clears the stage valid bits only; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU on Q3.12 operands: add, subtract, multiply, divide
// and magnitude, with saturation, overflow and divide-by-zero flags.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               op_valid,
  output logic                    op_ready,
  input  wire cau_pkg::in_item_t  op,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output cau_pkg::out_item_t      res
);

  localparam int DW   = cau_pkg::DATA_WIDTH;
  localparam int FB   = cau_pkg::FRAC_BITS;
  localparam int QB   = cau_pkg::QUO_BITS;
  localparam int PW   = cau_pkg::PROD_W;
  localparam int MW   = cau_pkg::MAG_W;
  localparam int SQW  = cau_pkg::SQ_W;
  localparam int NSH  = cau_pkg::NUM_SHIFT;
  localparam int NSTG = QB + 4;
  localparam int LAST = NSTG - 1;

  typedef struct packed {
    logic [2:0]           func;
    logic signed [DW:0]   as_re;
    logic signed [DW:0]   as_im;
    logic signed [PW-1:0] p_rr;
    logic signed [PW-1:0] p_ii;
    logic signed [PW-1:0] p_ri;
    logic signed [PW-1:0] p_ir;
    logic signed [PW-1:0] p_a2r;
    logic signed [PW-1:0] p_a2i;
    logic signed [PW-1:0] p_b2r;
    logic signed [PW-1:0] p_b2i;
  } s1_t;

  typedef struct packed {
    logic [2:0]    func;
    logic          neg_re;
    logic          neg_im;
    logic [MW-1:0] mag_re;
    logic [MW-1:0] mag_im;
    logic          nneg_re;
    logic          nneg_im;
    logic [PW-1:0] num_re;
    logic [PW-1:0] num_im;
    logic [PW-1:0] den;
    logic [PW-1:0] sq;
  } s2_t;

  logic [NSTG-1:0] v;
  logic [NSTG-1:0] en;

  s1_t            s1;
  s1_t            s1_next;
  s2_t            s2;
  s2_t            s2_next;
  cau_pkg::iter_t s3_next;
  cau_pkg::iter_t it [QB+1];
  cau_pkg::out_item_t res_next;

  function automatic logic [PW-1:0] abs_w(input logic signed [PW:0] x);
    logic [PW:0] m;
    m = x[PW] ? -x : x;
    return m[PW-1:0];
  endfunction

  function automatic logic [MW-1:0] round_frac(input logic [PW-1:0] m);
    return MW'(m >> FB) + MW'(m[FB-1]);
  endfunction

  function automatic logic [DW:0] sat(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] half;
    logic [MW-1:0] negm;
    half = MW'(1) << (DW - 1);
    negm = -mag;
    if (neg) begin
      if (mag > half) begin
        return {1'b1, 1'b1, {(DW-1){1'b0}}};
      end
      return {1'b0, negm[DW-1:0]};
    end
    if (mag > half - MW'(1)) begin
      return {1'b1, 1'b0, {(DW-1){1'b1}}};
    end
    return {1'b0, mag[DW-1:0]};
  endfunction

  // stall chain
  assign en[LAST] = !v[LAST] || res_ready;
  genvar g;
  generate
    for (g = 0; g < LAST; g++) begin : g_en
      assign en[g] = !v[g] || en[g+1];
    end
  endgenerate

  assign op_ready  = en[0];
  assign res_valid = v[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (en[i]) begin
          v[i] <= (i == 0) ? op_valid : v[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // stage 1: products and sums or differences
  always_comb begin
    s1_next.func  = op.func;
    if (op.func == cau_pkg::FUNC_SUB) begin
      s1_next.as_re = {op.a_re[DW-1], op.a_re} - {op.b_re[DW-1], op.b_re};
      s1_next.as_im = {op.a_im[DW-1], op.a_im} - {op.b_im[DW-1], op.b_im};
    end else begin
      s1_next.as_re = {op.a_re[DW-1], op.a_re} + {op.b_re[DW-1], op.b_re};
      s1_next.as_im = {op.a_im[DW-1], op.a_im} + {op.b_im[DW-1], op.b_im};
    end
    s1_next.p_rr  = PW'(op.a_re) * PW'(op.b_re);
    s1_next.p_ii  = PW'(op.a_im) * PW'(op.b_im);
    s1_next.p_ri  = PW'(op.a_re) * PW'(op.b_im);
    s1_next.p_ir  = PW'(op.a_im) * PW'(op.b_re);
    s1_next.p_a2r = PW'(op.a_re) * PW'(op.a_re);
    s1_next.p_a2i = PW'(op.a_im) * PW'(op.a_im);
    s1_next.p_b2r = PW'(op.b_re) * PW'(op.b_re);
    s1_next.p_b2i = PW'(op.b_im) * PW'(op.b_im);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1 <= s1_next;
    end
  end

  // stage 2: cross sums, rounding of the product
  logic signed [PW:0] mul_re;
  logic signed [PW:0] mul_im;
  logic signed [PW:0] dnum_re;
  logic signed [PW:0] dnum_im;
  logic [PW-1:0]      mul_mag_re;
  logic [PW-1:0]      mul_mag_im;
  logic [DW:0]        as_mag_re;
  logic [DW:0]        as_mag_im;

  assign mul_re  = {s1.p_rr[PW-1], s1.p_rr} - {s1.p_ii[PW-1], s1.p_ii};
  assign mul_im  = {s1.p_ri[PW-1], s1.p_ri} + {s1.p_ir[PW-1], s1.p_ir};
  assign dnum_re = {s1.p_rr[PW-1], s1.p_rr} + {s1.p_ii[PW-1], s1.p_ii};
  assign dnum_im = {s1.p_ir[PW-1], s1.p_ir} - {s1.p_ri[PW-1], s1.p_ri};
  assign mul_mag_re = abs_w(mul_re);
  assign mul_mag_im = abs_w(mul_im);
  assign as_mag_re  = s1.as_re[DW] ? -s1.as_re : s1.as_re;
  assign as_mag_im  = s1.as_im[DW] ? -s1.as_im : s1.as_im;

  always_comb begin
    s2_next.func    = s1.func;
    s2_next.nneg_re = dnum_re[PW];
    s2_next.nneg_im = dnum_im[PW];
    s2_next.num_re  = abs_w(dnum_re);
    s2_next.num_im  = abs_w(dnum_im);
    s2_next.den     = PW'(s1.p_b2r) + PW'(s1.p_b2i);
    s2_next.sq      = PW'(s1.p_a2r) + PW'(s1.p_a2i);
    if (s1.func == cau_pkg::FUNC_MUL) begin
      s2_next.neg_re = mul_re[PW];
      s2_next.neg_im = mul_im[PW];
      s2_next.mag_re = round_frac(mul_mag_re);
      s2_next.mag_im = round_frac(mul_mag_im);
    end else begin
      s2_next.neg_re = s1.as_re[DW];
      s2_next.neg_im = s1.as_im[DW];
      s2_next.mag_re = MW'(as_mag_re);
      s2_next.mag_im = MW'(as_mag_im);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2 <= s2_next;
    end
  end

  // stage 3: divider and root setup
  always_comb begin
    s3_next.func   = s2.func;
    s3_next.dz     = (s2.func == cau_pkg::FUNC_DIV) && (s2.den == '0);
    s3_next.neg_re = (s2.func == cau_pkg::FUNC_DIV) ? s2.nneg_re : s2.neg_re;
    s3_next.neg_im = (s2.func == cau_pkg::FUNC_DIV) ? s2.nneg_im : s2.neg_im;
    s3_next.mag_re = s2.mag_re;
    s3_next.mag_im = s2.mag_im;
    s3_next.num_re = s2.num_re;
    s3_next.num_im = s2.num_im;
    s3_next.rem_re = s2.num_re >> NSH;
    s3_next.rem_im = s2.num_im >> NSH;
    s3_next.big_re = (s2.num_re >> NSH) >= s2.den;
    s3_next.big_im = (s2.num_im >> NSH) >= s2.den;
    s3_next.quo_re = '0;
    s3_next.quo_im = '0;
    s3_next.den    = s2.den;
    s3_next.sq_rem = SQW'(s2.sq);
    s3_next.root   = '0;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      it[0] <= s3_next;
    end
  end

  generate
    for (g = 0; g < QB; g++) begin : g_iter
      cau_iter_stage #(
        .STEP (QB - 1 - g)
      ) u_stage (
        .clk (clk),
        .en  (en[3+g]),
        .d   (it[g]),
        .q   (it[g+1])
      );
    end
  endgenerate

  // final stage: quotient rounding, root rounding, saturation
  cau_pkg::iter_t fin;
  logic [QB:0]    qr_re;
  logic [QB:0]    qr_im;
  logic [MW-1:0]  qmag_re;
  logic [MW-1:0]  qmag_im;
  logic [DW:0]    root_rnd;
  logic [DW:0]    sat_re;
  logic [DW:0]    sat_im;

  assign fin      = it[QB];
  assign qr_re    = ({1'b0, fin.quo_re} + (QB+1)'(1)) >> 1;
  assign qr_im    = ({1'b0, fin.quo_im} + (QB+1)'(1)) >> 1;
  assign qmag_re  = fin.big_re ? '1 : MW'(qr_re);
  assign qmag_im  = fin.big_im ? '1 : MW'(qr_im);
  assign root_rnd = {1'b0, fin.root} + (DW+1)'(fin.sq_rem > SQW'(fin.root));

  always_comb begin
    sat_re   = '0;
    sat_im   = '0;
    res_next = '0;
    unique case (fin.func) inside
      cau_pkg::FUNC_ADD, cau_pkg::FUNC_SUB, cau_pkg::FUNC_MUL: begin
        sat_re = sat(fin.neg_re, fin.mag_re);
        sat_im = sat(fin.neg_im, fin.mag_im);
        res_next.res_re   = sat_re[DW-1:0];
        res_next.res_im   = sat_im[DW-1:0];
        res_next.overflow = sat_re[DW] | sat_im[DW];
      end
      cau_pkg::FUNC_DIV: begin
        if (fin.dz) begin
          res_next.div_by_zero = 1'b1;
        end else begin
          sat_re = sat(fin.neg_re, qmag_re);
          sat_im = sat(fin.neg_im, qmag_im);
          res_next.res_re   = sat_re[DW-1:0];
          res_next.res_im   = sat_im[DW-1:0];
          res_next.overflow = sat_re[DW] | sat_im[DW];
        end
      end
      cau_pkg::FUNC_MAG: begin
        sat_re = sat(1'b0, MW'(root_rnd));
        res_next.res_re   = sat_re[DW-1:0];
        res_next.overflow = sat_re[DW];
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      res <= res_next;
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.div_by_zero |->
      res.res_re == '0 && res.res_im == '0 && !res.overflow)
    else $error("divide by zero item with nonzero result");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    res_ready |-> op_ready)
    else $error("input stalled while output side is ready");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready |=> v[0])
    else $error("accepted item lost at first stage");

  a_mag_pos: assert property (@(posedge clk) disable iff (rst)
    v[LAST-1] && en[LAST] && fin.func == cau_pkg::FUNC_MAG |=>
      res_valid && !res.res_re[DW-1] && res.res_im == '0)
    else $error("magnitude result negative or with imaginary part");

endmodule
`default_nettype wire
